[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cnf3_pkg.sv]
package cnf3_pkg;

	// Sizing of the assignment store and of the clause counter.
	localparam int NVARS       = 1024;
	localparam int MAX_CLAUSES = 4096;
	localparam int ADDR_W      = (NVARS > 1) ? $clog2(NVARS) : 1;
	localparam int LIT_W       = 12;
	localparam int VIDX_W      = 10;
	localparam int COUNT_W     = 13;
	localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
	localparam int COUNT_LIMIT = (MAX_CLAUSES < COUNT_MAX) ? MAX_CLAUSES : COUNT_MAX;
	localparam int NLANES      = 3;

	typedef logic [ADDR_W-1:0] addr_t;

	// Operation codes carried by an input beat.
	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_SCORE  = 2'd1,
		ACT_REPAIR = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FLIP_A,
		ST_FLIP_B,
		ST_FLIP_C,
		ST_DONE
	} state_t;

	// Input beat.
	typedef struct packed {
		logic [1:0]              action;
		logic [VIDX_W-1:0]       var_index;
		logic                    var_value;
		logic signed [LIT_W-1:0] lit_a;
		logic signed [LIT_W-1:0] lit_b;
		logic signed [LIT_W-1:0] lit_c;
		logic                    flip_a;
		logic                    flip_b;
		logic                    flip_c;
		logic                    last_clause;
	} item_t;

	// Output beat.
	typedef struct packed {
		logic               clause_true;
		logic [COUNT_W-1:0] satisfied_count;
		logic               count_valid;
	} result_t;

	// Write port broadcast to every lane's copy of the assignment.
	typedef struct packed {
		logic  en;
		addr_t addr;
		logic  data;
	} wr_t;

	// What one lane found for its literal.
	typedef struct packed {
		logic  ok;
		logic  raw;
		logic  val;
		addr_t idx;
	} lane_t;

	// Control from the sequencer to the merge stage.
	typedef struct packed {
		logic eval;
		logic score;
		logic last;
	} merge_ctl_t;

	// Combined verdict of the lanes.
	typedef struct packed {
		logic              sat;
		logic [NLANES-1:0] flip_en;
		logic [NLANES-1:0] flip_data;
	} merge_t;

endpackage

[rtl/cnf3_ram.sv]
module cnf3_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/cnf3_lane.sv]
module cnf3_lane (
	input  logic                              clk,
	input  logic                              capture,
	input  logic signed [cnf3_pkg::LIT_W-1:0] lit,
	input  cnf3_pkg::wr_t                     wr,
	output cnf3_pkg::lane_t                   lane
);
	import cnf3_pkg::*;

	logic             neg;
	logic [LIT_W:0]   mag;
	logic             ok;
	addr_t            addr;
	logic             ok_q;
	logic             neg_q;
	addr_t            addr_q;
	logic [0:0]       rdata;

	// Decode the signed one-based literal into a variable address.
	always_comb begin
		neg  = lit[LIT_W-1];
		mag  = neg ? (((LIT_W+1)'(1) << LIT_W) - {1'b0, lit}) : {1'b0, lit};
		ok   = (mag != '0) && (32'(mag) <= NVARS);
		addr = ADDR_W'(mag - 1'b1);
	end

	// Hold the decode of the accepted beat while the sequencer works on it.
	always_ff @(posedge clk) begin
		if (capture) begin
			ok_q   <= ok;
			neg_q  <= neg;
			addr_q <= addr;
		end
	end

	// This lane's private copy of the assignment; every copy sees the same writes.
	cnf3_ram #(
		.WIDTH(1),
		.DEPTH(NVARS)
	) u_ram (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.data),
		.re   (capture),
		.raddr(addr),
		.rdata(rdata)
	);

	// A literal that names no stored variable reads as false.
	always_comb begin
		lane.ok  = ok_q;
		lane.raw = rdata[0];
		lane.val = ok_q & (rdata[0] ^ neg_q);
		lane.idx = addr_q;
	end

endmodule

[rtl/cnf3_merge.sv]
module cnf3_merge (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  cnf3_pkg::lane_t [cnf3_pkg::NLANES-1:0]  lanes,
	input  logic [cnf3_pkg::NLANES-1:0]             flips,
	input  cnf3_pkg::merge_ctl_t                    ctl,
	output cnf3_pkg::merge_t                        res,
	output logic [cnf3_pkg::COUNT_W-1:0]            count
);
	import cnf3_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic               par;

	// Clause verdict and the toggle value of each lane. Earlier toggles of the
	// same variable in this clause are folded in, so duplicates cancel.
	always_comb begin
		res.sat       = 1'b0;
		res.flip_en   = '0;
		res.flip_data = '0;
		par           = 1'b0;
		for (int k = 0; k < NLANES; k++) begin
			res.sat        = res.sat | lanes[k].val;
			res.flip_en[k] = lanes[k].ok & flips[k];
		end
		for (int k = 0; k < NLANES; k++) begin
			par = 1'b0;
			for (int j = 0; j < k; j++) begin
				if (res.flip_en[j] && (lanes[j].idx == lanes[k].idx)) begin
					par = ~par;
				end
			end
			res.flip_data[k] = ~lanes[k].raw ^ par;
		end
	end

	// Reported count: the pass total including this clause, saturating.
	always_comb begin
		count = count_q;
		if (ctl.score && res.sat && (count_q < COUNT_W'(COUNT_LIMIT))) begin
			count = count_q + 1'b1;
		end
	end

	// The pass counter advances on scored beats and clears after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.eval && ctl.score) begin
			count_q <= ctl.last ? '0 : count;
		end
	end

endmodule

[rtl/cnf3_clause_evaluate_repair.sv]
// An accepted beat is decoded and read from the assignment copies; its result
// is formed in the evaluate state, an unsatisfied repair clause then toggles its
// variables on the write port in the FLIP_A, FLIP_B and FLIP_C states, and the
// result is loaded into the output register when that is free. Only then is a
// new beat taken. Reset clears the pass count, the sequencer and the output valid;
// the assignment store is not cleared and holds no defined value until written.
module cnf3_clause_evaluate_repair (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  cnf3_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output cnf3_pkg::result_t result
);
	import cnf3_pkg::*;

	state_t                 state_q;
	state_t                 state_d;
	item_t                  item_q;
	result_t                res_q;
	result_t                out_q;
	logic                   out_valid_q;
	logic                   accept;
	logic                   out_free;
	logic                   out_load;
	logic                   is_score;
	logic                   is_load;
	logic                   need_repair;
	wr_t                    wr;
	merge_ctl_t             ctl;
	merge_t                 merged;
	lane_t [NLANES-1:0]     lanes;
	logic [NLANES-1:0]      flips;
	logic [COUNT_W-1:0]     count;

	assign accept   = item_valid && !item_stall;
	assign out_free = !out_valid_q || !result_stall;
	assign is_score = (item_q.action == ACT_SCORE) || (item_q.action == ACT_REPAIR);
	assign is_load  = (item_q.action == ACT_LOAD);
	assign need_repair = (item_q.action == ACT_REPAIR) && !merged.sat;
	assign flips    = {item_q.flip_c, item_q.flip_b, item_q.flip_a};

	// Three literal lanes, each with its own copy of the assignment.
	cnf3_lane u_lane_a (
		.clk    (clk),
		.capture(accept),
		.lit    (item.lit_a),
		.wr     (wr),
		.lane   (lanes[0])
	);

	cnf3_lane u_lane_b (
		.clk    (clk),
		.capture(accept),
		.lit    (item.lit_b),
		.wr     (wr),
		.lane   (lanes[1])
	);

	cnf3_lane u_lane_c (
		.clk    (clk),
		.capture(accept),
		.lit    (item.lit_c),
		.wr     (wr),
		.lane   (lanes[2])
	);

	// Merge the lane verdicts and keep the pass count.
	cnf3_merge u_merge (
		.clk   (clk),
		.arst_n(arst_n),
		.lanes (lanes),
		.flips (flips),
		.ctl   (ctl),
		.res   (merged),
		.count (count)
	);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = need_repair ? ST_FLIP_A : ST_DONE;
			end
			ST_FLIP_A: begin
				state_d = ST_FLIP_B;
			end
			ST_FLIP_B: begin
				state_d = ST_FLIP_C;
			end
			ST_FLIP_C: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output logic of the sequencer: handshake, store writes, merge control.
	always_comb begin
		item_stall = 1'b1;
		out_load   = 1'b0;
		wr.en      = 1'b0;
		wr.addr    = ADDR_W'(item_q.var_index);
		wr.data    = item_q.var_value;
		ctl.eval   = 1'b0;
		ctl.score  = is_score;
		ctl.last   = item_q.last_clause;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
			end
			ST_EVAL: begin
				ctl.eval = 1'b1;
				wr.en    = is_load && (32'(item_q.var_index) < NVARS);
			end
			ST_FLIP_A: begin
				wr.en   = merged.flip_en[0];
				wr.addr = lanes[0].idx;
				wr.data = merged.flip_data[0];
			end
			ST_FLIP_B: begin
				wr.en   = merged.flip_en[1];
				wr.addr = lanes[1].idx;
				wr.data = merged.flip_data[1];
			end
			ST_FLIP_C: begin
				wr.en   = merged.flip_en[2];
				wr.addr = lanes[2].idx;
				wr.data = merged.flip_data[2];
			end
			ST_DONE: begin
				out_load = out_free;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the accepted beat and the result formed in the evaluate cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (state_q == ST_EVAL) begin
			res_q.clause_true     <= is_score && merged.sat;
			res_q.satisfied_count <= count;
			res_q.count_valid     <= is_score && item_q.last_clause;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

[rtl/cnf3_checker.sv]
`include "assert_macros.svh"

module cnf3_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input cnf3_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input cnf3_pkg::result_t result
);
	import cnf3_pkg::*;

	// A stalled result beat holds.
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result beat changed")

	// One beat at a time: the input stalls right after an accepted beat.
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, item_valid && !item_stall, item_stall, "input accepted while a beat is in flight")

	// The reported count never passes the saturation limit.
	`ASSERT_IMPLIES(a_count_limit, clk, arst_n, result_valid, result.satisfied_count <= COUNT_W'(COUNT_LIMIT), "satisfied count above limit")

	// A satisfied clause reports a nonzero count, as the count includes it up to the limit.
	`ASSERT_IMPLIES(a_true_counted, clk, arst_n, result_valid && result.clause_true, result.satisfied_count != '0, "satisfied clause reported with zero count")

endmodule

bind cnf3_clause_evaluate_repair cnf3_checker u_checker (.*);

[tb/sv/cnf3_clause_evaluate_repair_tb.sv]
module cnf3_clause_evaluate_repair_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cnf3_pkg::*;

	// One row of the directed table: a beat and, where it is obvious, its result.
	typedef struct {
		item_t   it;
		bit      given;
		result_t want;
	} row_t;

	// What the sender says about the result of a beat it offers.
	typedef struct {
		bit      given;
		result_t want;
	} note_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// Copy of the block's state kept by the predictor.
	bit          truth [NVARS];
	int unsigned pass_tally;

	// Variables the stimulus has loaded; only these are ever looked up by a scored or repair clause.
	bit loaded [NVARS];
	int loaded_list [$];

	row_t    plan [$];
	note_t   notes [$];
	result_t open_verdicts [$];

	int  beats_sent;
	int  results_seen;
	int  mismatches;
	int  n_loads;
	int  n_clauses;
	int  n_repairs;
	int  n_passes;
	bit  calm;
	bit  hold_req;

	cnf3_clause_evaluate_repair DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Give up on a hung run.
	initial begin
		#40ms;
		$display("cnf3_clause_evaluate_repair verification failed");
		$finish;
	end

	// Decode a literal; returns 1 when it names a stored variable.
	function automatic bit lit_lookup(logic signed [LIT_W-1:0] lit, output int vidx);
		int mag;
		mag = (lit < 0) ? -int'(lit) : int'(lit);
		vidx = mag - 1;
		return (mag != 0) && (mag <= NVARS);
	endfunction

	// Work out the result of one accepted beat and advance the state copy.
	function automatic result_t clause_verdict(item_t it);
		result_t                 r;
		logic signed [LIT_W-1:0] lits [3];
		bit                      flips [3];
		bit                      ok [3];
		int                      vi [3];
		bit                      sat;
		r = '0;
		if (it.action == ACT_LOAD || it.action == ACT_NONE) begin
			if (it.action == ACT_LOAD && it.var_index < NVARS)
				truth[it.var_index] = it.var_value;
			r.satisfied_count = COUNT_W'(pass_tally);
			return r;
		end
		lits = '{it.lit_a, it.lit_b, it.lit_c};
		flips = '{it.flip_a, it.flip_b, it.flip_c};
		sat = 1'b0;
		for (int k = 0; k < 3; k++) begin
			ok[k] = lit_lookup(lits[k], vi[k]);
			if (ok[k] && (truth[vi[k]] ^ (lits[k] < 0)))
				sat = 1'b1;
		end
		if (sat && pass_tally < COUNT_LIMIT)
			pass_tally++;
		// An unsatisfied clause in repair mode toggles its enabled variables in order.
		if (!sat && it.action == ACT_REPAIR) begin
			for (int k = 0; k < 3; k++) begin
				if (ok[k] && flips[k])
					truth[vi[k]] = ~truth[vi[k]];
			end
		end
		r.clause_true = sat;
		r.satisfied_count = COUNT_W'(pass_tally);
		if (it.last_clause) begin
			r.count_valid = 1'b1;
			pass_tally = 0;
		end
		return r;
	endfunction

	function automatic result_t verdict(int t, int cnt, int cv);
		result_t r;
		r.clause_true = 1'(t);
		r.satisfied_count = COUNT_W'(cnt);
		r.count_valid = 1'(cv);
		return r;
	endfunction

	// Append one row to the directed table.
	function automatic void add_row(item_t it, bit given, result_t want);
		row_t r;
		r.it = it;
		r.given = given;
		r.want = want;
		plan.insert(plan.size(), r);
	endfunction

	function automatic item_t random_base();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return item_t'(raw[$bits(item_t)-1:0]);
	endfunction

	function automatic item_t load_of(int idx, bit val, bit last);
		item_t it;
		it = random_base();
		it.action = ACT_LOAD;
		it.var_index = VIDX_W'(idx);
		it.var_value = val;
		it.last_clause = last;
		if (!loaded[idx]) begin
			loaded[idx] = 1'b1;
			loaded_list.insert(loaded_list.size(), idx);
		end
		return it;
	endfunction

	function automatic item_t clause(action_t act, int a, int b, int c, bit [2:0] flips,
			bit last);
		item_t it;
		it = random_base();
		it.action = act;
		it.lit_a = LIT_W'(a);
		it.lit_b = LIT_W'(b);
		it.lit_c = LIT_W'(c);
		{it.flip_a, it.flip_b, it.flip_c} = flips;
		it.last_clause = last;
		return it;
	endfunction

	// Mostly literals of loaded variables, some zero, some beyond the store.
	function automatic int pick_literal();
		int sel;
		int m;
		sel = $urandom_range(0, 9);
		if (sel < 7) begin
			m = loaded_list[$urandom_range(0, loaded_list.size() - 1)] + 1;
			return $urandom_range(0, 1) ? -m : m;
		end
		if (sel == 7)
			return 0;
		m = $urandom_range(NVARS + 1, 2048);
		return (m == 2048 || $urandom_range(0, 1)) ? -m : m;
	endfunction

	function automatic item_t random_clause(bit last);
		return clause($urandom_range(0, 1) ? ACT_REPAIR : ACT_SCORE, pick_literal(),
			pick_literal(), pick_literal(), 3'($urandom()), last);
	endfunction

	// Offer one beat and hold it until the block takes it.
	task automatic offer(item_t it, bit given, result_t want);
		note_t nt;
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		nt.given = given;
		nt.want = want;
		notes.insert(notes.size(), nt);
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		beats_sent++;
	endtask

	// Stop offering until every result of the beats sent so far has come back.
	task automatic drain();
		item_valid <= 1'b0;
		while (results_seen < beats_sent) @(posedge clk);
	endtask

	// Passes of random clauses, mostly closed by a last beat, with loads and noise mixed in.
	task automatic random_passes(int budget);
		int stop;
		int len;
		stop = beats_sent + budget;
		while (beats_sent < stop) begin
			repeat ($urandom_range(0, 3))
				offer(load_of($urandom_range(0, NVARS - 1), 1'($urandom_range(0, 1)),
					1'b0), 1'b0, '0);
			len = $urandom_range(1, 20);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 15) == 0) begin
					if ($urandom_range(0, 1))
						offer(clause(ACT_NONE, pick_literal(), 0, 0, 3'($urandom()),
							1'($urandom_range(0, 1))), 1'b0, '0);
					else
						offer(load_of($urandom_range(0, NVARS - 1),
							1'($urandom_range(0, 1)), 1'b1), 1'b0, '0);
				end
				offer(random_clause(k == len - 1 && $urandom_range(0, 9) != 0), 1'b0, '0);
			end
		end
	endtask

	function automatic void report(string what, result_t want, result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected true=%0b count=%0d last=%0b, got true=%0b count=%0d last=%0b",
				$realtime, what, want.clause_true, want.satisfied_count, want.count_valid,
				got.clause_true, got.satisfied_count, got.count_valid);
	endfunction

	// Predict on every accepted input beat, check every accepted result beat.
	always @(posedge clk) begin : watch
		note_t   n;
		result_t guess;
		result_t want;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				guess = clause_verdict(item);
				n = notes.pop_front();
				open_verdicts.insert(open_verdicts.size(), n.given ? n.want : guess);
				if (item.action == ACT_LOAD)
					n_loads++;
				else if (item.action == ACT_SCORE)
					n_clauses++;
				else if (item.action == ACT_REPAIR) begin
					n_clauses++;
					n_repairs++;
				end
			end
			if (result_valid && !result_stall) begin
				results_seen++;
				if (result.count_valid)
					n_passes++;
				if (open_verdicts.size() == 0)
					report("result beat with nothing outstanding", '0, result);
				else begin
					want = open_verdicts.pop_front();
					if (result.clause_true !== want.clause_true
							|| result.satisfied_count !== want.satisfied_count
							|| result.count_valid !== want.count_valid)
						report("result mismatch", want, result);
				end
			end
		end
	end

	// Receiver: random stall bursts, and one long hold-off on request.
	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (250) @(posedge clk);
				result_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Sender and sequence of the run.
	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		calm = 1'b0;
		hold_req = 1'b0;

		// Directed rows: loads at both ends of the store, then clause corner cases.
		add_row(load_of(0, 1'b1, 1'b0), 1'b1, verdict(0, 0, 0));
		add_row(load_of(NVARS - 1, 1'b0, 1'b0), 1'b1, verdict(0, 0, 0));
		add_row(load_of(1, 1'b0, 1'b0), 1'b1, verdict(0, 0, 0));
		add_row(load_of(2, 1'b1, 1'b0), 1'b1, verdict(0, 0, 0));
		add_row(clause(ACT_NONE, 5, -7, 0, 3'b111, 1'b0), 1'b1, verdict(0, 0, 0));
		add_row(clause(ACT_SCORE, 0, 0, 0, 3'b111, 1'b0), 1'b1, verdict(0, 0, 0));
		add_row(clause(ACT_SCORE, 2047, -2048, 1025, 3'b111, 1'b0), 1'b1,
			verdict(0, 0, 0));
		add_row(clause(ACT_REPAIR, -1025, 0, 1500, 3'b111, 1'b0), 1'b1,
			verdict(0, 0, 0));
		add_row(clause(ACT_SCORE, 1, 0, 0, 3'b000, 1'b0), 1'b0, '0);
		add_row(clause(ACT_SCORE, -NVARS, 0, 0, 3'b000, 1'b0), 1'b0, '0);
		add_row(clause(ACT_SCORE, NVARS, -1, 2, 3'b111, 1'b0), 1'b0, '0);
		add_row(clause(ACT_REPAIR, NVARS, -1, 2, 3'b111, 1'b0), 1'b0, '0);
		add_row(clause(ACT_SCORE, NVARS, -1, 2, 3'b000, 1'b0), 1'b0, '0);
		add_row(load_of(4, 1'b0, 1'b1), 1'b0, '0);
		// A duplicated literal toggles twice and a zero literal never toggles.
		add_row(clause(ACT_REPAIR, -3, -3, 0, 3'b111, 1'b0), 1'b0, '0);
		add_row(clause(ACT_SCORE, 3, 0, 0, 3'b000, 1'b0), 1'b0, '0);
		add_row(clause(ACT_REPAIR, -2, -2, -2, 3'b000, 1'b0), 1'b0, '0);
		add_row(clause(ACT_REPAIR, 1, -2, -NVARS, 3'b101, 1'b0), 1'b0, '0);
		add_row(clause(ACT_REPAIR, 1, -NVARS, 0, 3'b111, 1'b0), 1'b0, '0);
		add_row(clause(ACT_SCORE, 0, 0, 0, 3'b000, 1'b1), 1'b0, '0);
		add_row(load_of(3, 1'b1, 1'b1), 1'b1, verdict(0, 0, 0));
		add_row(clause(ACT_SCORE, 0, 0, 0, 3'b000, 1'b1), 1'b1, verdict(0, 0, 1));
		add_row(clause(ACT_NONE, 1, 2, 3, 3'b111, 1'b1), 1'b1, verdict(0, 0, 0));
		add_row(clause(ACT_SCORE, 2047, -2047, 1025, 3'b111, 1'b1), 1'b1,
			verdict(0, 0, 1));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			offer(plan[i].it, plan[i].given, plan[i].want);
		drain();

		random_passes(300);

		// Long receiver hold-off while beats keep coming, so the block backs up.
		calm = 1'b1;
		hold_req = 1'b1;
		repeat (40)
			offer(random_clause($urandom_range(0, 7) == 0), 1'b0, '0);
		calm = 1'b0;
		drain();

		random_passes(250);

		// Last part without idling.
		calm = 1'b1;
		random_passes(100);
		drain();
		repeat (12) @(posedge clk);

		if (open_verdicts.size() != 0) begin
			mismatches += open_verdicts.size();
			$display("%0d expected results never arrived", open_verdicts.size());
		end
		$display("Covered %0d beats: %0d loads and %0d clauses, %0d of them repairs.",
			beats_sent, n_loads, n_clauses, n_repairs);
		$display("%0d passes closed, with stall bursts, a long hold-off and drains; %0d failures.",
			n_passes, mismatches);
		if (mismatches == 0)
			$display("cnf3_clause_evaluate_repair verification clean");
		else
			$display("cnf3_clause_evaluate_repair verification failed");
		$finish;
	end

endmodule
